### hdl/lru_key_value_cache_core_assert.svh
// assertion macros for the lru key-value cache core
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LKVC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// next-cycle implication, sampled on clk, off during rst
`define LKVC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

### hdl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int DATA_W           = 32;
  localparam int CAP_W            = 5;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int MAX_ENTRIES_DEF  = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
  localparam logic [DATA_W-1:0] NOT_FOUND    = 32'hFFFF_FFFF;
  localparam logic              MODE_LOOKUP  = 1'b0;
  localparam logic              MODE_STORE   = 1'b1;
  localparam logic              REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] value_out;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic multi_hit;
    logic over_cap;
  } status_t;

endpackage

### hdl/lkvc_ctrl.sv
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic cfg_clear,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_MATCH;
      end
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy       = (state != ST_IDLE);
    cmd.load   = (state == ST_IDLE) && start;
    cmd.match  = (state == ST_MATCH);
    cmd.update = (state == ST_UPDATE);
    cmd.clear  = cfg_clear;
  end

endmodule

### hdl/lkvc_dp.sv
module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  req_t             req,
  input  logic [CAP_W-1:0] capacity,
  output rsp_t             result,
  output status_t          status
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OccW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (OccW > CAP_W) ? OccW : CAP_W;

  req_t req_q;

  // entry table
  logic [MAX_ENTRIES-1:0]    valid;
  logic signed [DATA_W-1:0]  key_tab  [MAX_ENTRIES];
  logic [IdxW-1:0]           rank_tab [MAX_ENTRIES];
  logic [OccW-1:0]           occ;
  logic [DATA_W-1:0]         val_mem  [MAX_ENTRIES];
  logic [DATA_W-1:0]         val_rd;

  // match stage results
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [IdxW-1:0] hit_rank_q;
  logic [IdxW-1:0] lru_idx_q;
  logic [IdxW-1:0] free_idx_q;
  logic [DATA_W-1:0] lru_key_q;
  logic            full_q;
  logic            occ_zero_q;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] lru_vec;
  logic [IdxW-1:0]        hit_idx;
  logic [IdxW-1:0]        lru_idx;
  logic [IdxW-1:0]        free_idx;
  logic [OccW-1:0]        occ_dec;
  logic [CmpW-1:0]        cap_ext;
  logic [CmpW-1:0]        max_ext;
  logic [CmpW-1:0]        eff_cap;
  logic [CmpW-1:0]        occ_ext;

  rsp_t            rsp_q;
  logic            store;
  logic            do_insert;
  logic            do_evict;
  logic            zero_cap;
  logic [IdxW-1:0] slot;
  logic [IdxW-1:0] wr_idx;
  logic            val_we;

  assign occ_dec = occ - 1'b1;
  assign cap_ext = CmpW'(capacity);
  assign max_ext = CmpW'(MAX_ENTRIES);
  assign eff_cap = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign occ_ext = CmpW'(occ);

  // parallel key compare and lru / free search
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i] = valid[i] && (key_tab[i] == req_q.key);
      lru_vec[i]   = valid[i] && (rank_tab[i] == occ_dec[IdxW-1:0]);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IdxW'(i);
      if (lru_vec[i])   lru_idx = IdxW'(i);
      if (!valid[i])    free_idx = IdxW'(i);
    end
  end

  assign status.multi_hit = |(match_vec & (match_vec - 1'b1));
  assign status.over_cap  = occ_ext > eff_cap;

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
    if (cmd.match) begin
      hit_q      <= |match_vec;
      hit_idx_q  <= hit_idx;
      hit_rank_q <= rank_tab[hit_idx];
      lru_idx_q  <= lru_idx;
      lru_key_q  <= key_tab[lru_idx];
      free_idx_q <= free_idx;
      full_q     <= occ_ext >= eff_cap;
      occ_zero_q <= (occ == '0);
    end
  end

  // update stage decode
  assign store     = (req_q.mode == MODE_STORE);
  assign do_insert = !hit_q && store && !full_q;
  assign do_evict  = !hit_q && store && full_q && !occ_zero_q;
  assign zero_cap  = !hit_q && store && full_q && occ_zero_q;
  assign slot      = do_evict ? lru_idx_q : free_idx_q;
  assign wr_idx    = hit_q ? hit_idx_q : slot;
  assign val_we    = cmd.update && ((hit_q && store) || do_insert || do_evict);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_tab[i] <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_q) begin
          if (IdxW'(i) == hit_idx_q) begin
            rank_tab[i] <= '0;
          end else if (valid[i] && (rank_tab[i] < hit_rank_q)) begin
            rank_tab[i] <= rank_tab[i] + 1'b1;
          end
        end else if (do_insert || do_evict) begin
          if (IdxW'(i) == slot) begin
            valid[i]    <= 1'b1;
            key_tab[i]  <= req_q.key;
            rank_tab[i] <= '0;
          end else if (valid[i]) begin
            rank_tab[i] <= rank_tab[i] + 1'b1;
          end
        end
      end
      if (do_insert) occ <= occ + 1'b1;
    end
  end

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (val_we) val_mem[wr_idx] <= req_q.value_in;
    if (cmd.match) val_rd <= val_mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp_q.hit       <= hit_q;
      rsp_q.value_out <= (hit_q && !store) ? val_rd : NOT_FOUND;
      rsp_q.evicted   <= do_evict || zero_cap;
      rsp_q.evicted_key <= do_evict ? lru_key_q : (zero_cap ? req_q.key : '0);
    end
  end

  assign result = rsp_q;

endmodule

### hdl/lru_key_value_cache_core.sv
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+----------------------------------
// request   | start, busy, req                        | taken when start && !busy
// result    | done, result                            | one cycle strobe, no back-pressure
// config    | psel penable pwrite paddr pwdata prdata | apb write, pready tied high
//
// a request passes through accept, key match and table update, in that order
// the result strobe shows in the cycle after update, alongside the next accept
// busy holds off start during key match and table update; a new request waits for idle
// rst is synchronous and empties the table; capacity returns to 16
// a capacity write empties the table at once; no clearing pass is needed
// the receiver cannot stall, so nothing holds a result back
`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request side
  input  logic                  start,
  input  req_t                  req,
  output logic                  busy,
  // result side
  output logic                  done,
  output rsp_t                  result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0] capacity;
  logic             cfg_clear;
  logic             accepted;
  cmd_t             cmd;
  status_t          dp_status;

  // capacity register; word address from bit 2, byte lanes ignored
  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_clear) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign accepted = start && !busy;

  // sequencer: idle -> match -> update
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_clear (cfg_clear),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  // key table, recency ranks, value store and result register
  lkvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .capacity (capacity),
    .result   (result),
    .status   (dp_status)
  );

  // an accepted request keeps the block busy while it is matched
  `LKVC_ASSERT_NEXT(a_accept_busy, accepted, busy)
  // the result strobe lands once the sequencer is back at idle
  `LKVC_ASSERT_NOW(a_done_idle, done, !busy)
  // the key of the held request is never found in two entries
  `LKVC_ASSERT_NOW(a_key_unique, 1'b1, !dp_status.multi_hit)
  // occupancy stays within the capacity in use between requests
  `LKVC_ASSERT_NOW(a_occ_cap, !busy, !dp_status.over_cap)

endmodule
